// ===== hdl/wrd_pkg.sv =====
package wrd_pkg;

  // Operand width in bits (8..64). Ports stay 64 bits wide; upper bits are ignored.
  localparam int WIDTH = 64;
  localparam int FIELD_W = 64;
  localparam int CNT_W = $clog2(WIDTH);

  typedef struct packed {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } wrd_operands_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient_out;
    logic [FIELD_W-1:0] remainder_out;
    logic               divide_by_zero;
  } wrd_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } wrd_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
  } wrd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic divisor_zero;
  } wrd_status_t;

endpackage

// ===== hdl/wide_restoring_divider_core.sv =====
// Unsigned restoring divider, WIDTH-bit operands (wrd_pkg::WIDTH, 64 by default).
// Command channel: a transfer happens at the clock edge where start is high and
// busy is low; operands carries dividend and divisor (bits at and above WIDTH
// are ignored).
// Result channel: done is high for exactly one cycle while result holds the
// quotient, remainder and divide_by_zero flag; the transfer completes at the
// edge ending that cycle. The receiver has no way to stall, so it must take it.
// Iteration: one quotient bit per cycle from the shared subtractor; done rises
// after the last of the WIDTH steps. busy stays high through the done cycle, so
// a new division is accepted only after the previous result has been delivered.
// A zero divisor skips the iteration: done follows in the next cycle with
// quotient and remainder zero and divide_by_zero set.
// Reset (rst, synchronous) returns the controller to idle and drops any
// division in flight; no result is produced for it.
module wide_restoring_divider_core
  import wrd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  wrd_operands_t operands,
  output logic          busy,
  output logic          done,
  output wrd_result_t   result
);

  wrd_cmd_t    cmd;     // load / step from the controller
  wrd_status_t status;  // divisor-zero detect back to the controller

  // Sequencer: idle -> run (WIDTH steps) -> done strobe; a zero divisor goes from idle straight to done.
  wrd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Remainder / quotient shift registers and the single subtractor.
  wrd_dpath u_dpath (
    .clk      (clk),
    .operands (operands),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

// ===== hdl/wrd_dpath.sv =====
module wrd_dpath
  import wrd_pkg::*;
(
  input  logic          clk,
  input  wrd_operands_t operands,
  input  wrd_cmd_t      cmd,
  output wrd_status_t   status,
  output wrd_result_t   result
);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;   // holds dividend bits, quotient bits shift in at the bottom
  logic [WIDTH-1:0] dvs;
  logic             dz;

  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] quo_next;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             fits;

  assign status.divisor_zero = (operands.divisor[WIDTH-1:0] == '0);

  // Partial remainder carries the extra top bit; borrow of diff decides the quotient bit.
  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign fits    = !diff[WIDTH+1];

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    if (cmd.load) begin
      rem_next = '0;
      quo_next = status.divisor_zero ? '0 : operands.dividend[WIDTH-1:0];
    end else if (cmd.step) begin
      rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_next = {quo[WIDTH-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    quo <= quo_next;
    if (cmd.load) begin
      dvs <= operands.divisor[WIDTH-1:0];
      dz  <= status.divisor_zero;
    end
  end

  assign result.quotient_out   = FIELD_W'(quo);
  assign result.remainder_out  = FIELD_W'(rem);
  assign result.divide_by_zero = dz;

endmodule

// ===== hdl/wrd_ctrl.sv =====
module wrd_ctrl
  import wrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  wrd_status_t status,
  output wrd_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  wrd_state_t       state;
  wrd_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = status.divisor_zero ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    busy     = 1'b1;
    done     = 1'b0;
    cnt_next = cnt;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        cnt_next = CNT_W'(WIDTH - 1);
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_next = cnt - CNT_W'(1);
      end
      ST_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (state == ST_IDLE))
    else $error("done strobe lasted more than one cycle");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cnt != '0) |=> (state == ST_RUN && cnt == $past(cnt) - CNT_W'(1)))
    else $error("bit counter skipped or run ended early");

  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !status.divisor_zero) |=> (state == ST_RUN && cnt == CNT_W'(WIDTH - 1)))
    else $error("load did not start a full-length run");

  a_zero_skips: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && status.divisor_zero) |=> (state == ST_DONE))
    else $error("zero divisor did not go straight to done");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import wrd_pkg::*;

  localparam int STALL_LIMIT  = 2000;     // cycles without any transfer
  localparam int SETTLE_TICKS = WIDTH + 16;
  localparam int RANDOM_ITEMS = 2000;

  // Keeps the results (quotient, remainder, divide_by_zero) still owed by the divider, oldest first.
  class div_tracker;
    wrd_result_t owed_results[$];
    int          errors = 0;

    function wrd_result_t expected_division(wrd_operands_t ops);
      logic [FIELD_W-1:0] mask;
      logic [FIELD_W-1:0] num;
      logic [FIELD_W-1:0] den;
      logic [FIELD_W:0]   partial;
      wrd_result_t        res;
      mask = '1;
      mask = mask >> (FIELD_W - WIDTH);
      num  = ops.dividend & mask;
      den  = ops.divisor & mask;
      res  = '0;
      if (den == '0) begin
        res.divide_by_zero = 1'b1;
      end else begin
        // partial stays below den before each shift, so WIDTH+1 bits suffice
        partial = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
          partial = {partial[FIELD_W-1:0], num[i]};
          if (partial >= {1'b0, den}) begin
            partial = partial - {1'b0, den};
            res.quotient_out[i] = 1'b1;
          end
        end
        res.remainder_out = partial[FIELD_W-1:0];
      end
      return res;
    endfunction

    function void note_operands(wrd_operands_t ops);
      owed_results.push_back(expected_division(ops));
    endfunction

    function void check_result(wrd_result_t got);
      wrd_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result q=%h r=%h dz=%b", $time,
                 got.quotient_out, got.remainder_out, got.divide_by_zero);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.quotient_out !== want.quotient_out) begin
        $display("%0t: quotient_out expected %h actual %h", $time,
                 want.quotient_out, got.quotient_out);
        errors++;
      end
      if (got.remainder_out !== want.remainder_out) begin
        $display("%0t: remainder_out expected %h actual %h", $time,
                 want.remainder_out, got.remainder_out);
        errors++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        $display("%0t: divide_by_zero expected %b actual %b", $time,
                 want.divide_by_zero, got.divide_by_zero);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  wrd_operands_t operands = '0;
  logic          busy;
  logic          done;
  wrd_result_t   result;

  div_tracker sb = new();
  int         idle_cycles = 0;

  wide_restoring_divider_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result and command transfers, plus the stall watchdog.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_operands(operands);
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic wrd_operands_t make_ops(logic [63:0] n, logic [63:0] d);
    wrd_operands_t ops;
    ops.dividend = n;
    ops.divisor  = d;
    return ops;
  endfunction

  // Mix of operand classes; plain random words rarely hit the corners.
  function automatic wrd_operands_t random_operands();
    logic [63:0] n;
    logic [63:0] d;
    n = rand_word();
    d = rand_word();
    case ($urandom_range(0, 15))
      0:       d = '0;
      1, 2:    d = d >> $urandom_range(56, 63);                 // small divisor
      3:       begin d[63] = 1'b1; n = n >> 1; end              // quotient zero
      4:       d = 64'd1 << $urandom_range(0, 63);              // power of two
      5:       d = n + 64'($urandom_range(0, 4)) - 64'd2;       // divisor near dividend
      6:       begin n[63] = 1'b1; d[63] = 1'b1; end
      7, 8:    begin
                 n = n >> $urandom_range(0, 63);
                 d = d >> $urandom_range(0, 63);
               end
      9:       n = '1;
      default: ;
    endcase
    return make_ops(n, d);
  endfunction

  // One command transfer: optional drain, gap cycles, then start held until taken.
  task automatic send_operands(wrd_operands_t ops, int gap, bit drain);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      if (drain) begin
        @(posedge clk);
        while (sb.owed_results.size() != 0) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    operands <= ops;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    wrd_operands_t directed[$];
    int            gap;
    bit            burst;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(make_ops(64'd0, 64'd0));
    directed.push_back(make_ops('1, 64'd0));
    directed.push_back(make_ops('1, 64'd1));
    directed.push_back(make_ops('1, '1));
    directed.push_back(make_ops(64'd0, '1));
    directed.push_back(make_ops(64'd1, '1));
    directed.push_back(make_ops('1, 64'h8000_0000_0000_0000));
    directed.push_back(make_ops(64'h8000_0000_0000_0000, '1));
    directed.push_back(make_ops(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000));
    directed.push_back(make_ops('1, 64'h7fff_ffff_ffff_ffff));
    directed.push_back(make_ops(64'hfffe_0000_0000_0001, 64'hffff_ffff));
    directed.push_back(make_ops(64'd5, 64'd3));
    directed.push_back(make_ops(64'd3, 64'd5));
    directed.push_back(make_ops(64'd7, 64'd7));
    directed.push_back(make_ops(64'd0, 64'd1));
    directed.push_back(make_ops(64'd1, 64'd1));
    directed.push_back(make_ops('1, 64'd2));
    directed.push_back(make_ops(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555));
    directed.push_back(make_ops(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa));
    directed.push_back(make_ops(64'h1234_5678_9abc_def0, 64'd0));

    foreach (directed[i]) send_operands(directed[i], $urandom_range(0, 3), 1'b0);

    burst = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 15);
      send_operands(random_operands(), gap, (i == RANDOM_ITEMS / 2));
    end
    start <= 1'b0;

    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
